### design/laser_temp_mpd_compensation_top_assert.svh
// Assertion helpers for the laser temperature and MPD compensation block
`ifndef LASER_TEMP_MPD_COMPENSATION_TOP_ASSERT_SVH
`define LASER_TEMP_MPD_COMPENSATION_TOP_ASSERT_SVH

// same-cycle implication
`define LMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lmc assertion failed");

// next-cycle implication
`define LMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmc assertion failed");

`endif

### design/lmc_pkg.sv
package lmc_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ADC_SLOPE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADC_OFFSET  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORM_TEMP   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ETC_DELTA   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_P0_BASE     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_P1_BASE     = 4'd7;

	localparam logic [1:0] MODE_DUAL_CLOSED = 2'd0;

	// reciprocals: x/125 for x < 2^37, x/625 for x < 2^33, x/1000 for x < 2^20
	localparam logic [37:0] RECIP_125  = 38'd140737488356;
	localparam logic [33:0] RECIP_625  = 34'd14073748836;
	localparam logic [20:0] RECIP_1000 = 21'd1073742;
	localparam logic [14:0] RECIP_25   = 15'd10486;
	localparam logic [14:0] RECIP_10   = 15'd26215;

	// beyond this the fit term always saturates the temperature
	localparam logic [32:0] FIT_BIG_Z  = 33'd5242880000;
	localparam logic [23:0] FIT_CLAMP  = 24'd8388608;
	localparam logic [6:0]  TOFF_SCALE = 7'd100;

	localparam int TEMP_LIMIT_MC = 1000000;

	localparam logic signed [11:0] HOT_SPAN  = 12'sd25;
	localparam logic signed [11:0] COLD_GAP  = 12'sd20;
	localparam logic signed [11:0] COLD_SPAN = 12'sd30;

	typedef struct packed {
		logic [23:0]        adc_slope_nanovolt;
		logic signed [22:0] adc_offset_microvolt;
		logic [15:0]        temp_offset_tenths;
		logic [15:0]        temp_slope_tenths;
		logic [7:0]         norm_temp_deg;
		logic [31:0]        etc_delta_word;
		logic [9:0]         p0_base_target;
		logic [9:0]         p1_base_target;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		adc_slope_nanovolt:   24'd0,
		adc_offset_microvolt: 23'sd0,
		temp_offset_tenths:   16'd4958,
		temp_slope_tenths:    16'd3275,
		norm_temp_deg:        8'd40,
		etc_delta_word:       32'd0,
		p0_base_target:       10'd0,
		p1_base_target:       10'd0
	};

	typedef struct packed {
		logic [15:0] temp_code;
		logic [1:0]  mode;
	} in_t;

	typedef struct packed {
		logic signed [20:0] ic_temp_millideg;
		logic [15:0]        mpdl_target;
		logic [15:0]        mpdh_target;
		logic               targets_written;
	} out_t;

endpackage

### design/lmc_regs.sv
module lmc_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lmc_pkg::CFG_DATA_W-1:0] cfg_data,
	output lmc_pkg::cfg_t                  cfg
);
	import lmc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ADC_SLOPE:   cfg_q.adc_slope_nanovolt   <= cfg_data[23:0];
				REG_ADC_OFFSET:  cfg_q.adc_offset_microvolt <= $signed(cfg_data[22:0]);
				REG_TEMP_OFFSET: cfg_q.temp_offset_tenths   <= cfg_data[15:0];
				REG_TEMP_SLOPE:  cfg_q.temp_slope_tenths    <= cfg_data[15:0];
				REG_NORM_TEMP:   cfg_q.norm_temp_deg        <= cfg_data[7:0];
				REG_ETC_DELTA:   cfg_q.etc_delta_word       <= cfg_data;
				REG_P0_BASE:     cfg_q.p0_base_target       <= cfg_data[9:0];
				REG_P1_BASE:     cfg_q.p1_base_target       <= cfg_data[9:0];
				default:         cfg_q                      <= cfg_q;
			endcase
		end
	end

endmodule

### design/laser_temp_mpd_compensation_top.sv
// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// sample    | sample_valid, sample_stall | temp_code, mode
// result    | result_valid, result_stall | ic_temp_millideg, mpdl/mpdh, written
// cfg       | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// One request enters per cycle while sample_stall is low; each result passes
// through the 13 stages s1 to s13 in order and leaves from s13.
// Reset clears every stage valid bit and loads the register defaults.
// A stalled result holds its stage; upstream stages keep filling bubbles, and
// sample_stall rises only once every stage holds a request.
module laser_temp_mpd_compensation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  lmc_pkg::in_t                   sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output lmc_pkg::out_t                  result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lmc_pkg::*;

`include "laser_temp_mpd_compensation_top_assert.svh"

	localparam logic [1:0] ZONE_NONE = 2'd0;
	localparam logic [1:0] ZONE_HOT  = 2'd1;
	localparam logic [1:0] ZONE_COLD = 2'd2;

	localparam logic signed [25:0] MC_HI  = 26'(TEMP_LIMIT_MC);
	localparam logic signed [20:0] RES_HI = 21'(TEMP_LIMIT_MC);

	function automatic logic [15:0] rail_comp(input logic [1:0] zone, input logic sat,
			input logic [7:0] d, input logic [9:0] c);
		logic [15:0] mag;
		mag = sat ? {8'b0, d} : {6'b0, c};
		case (zone)
			ZONE_HOT:  rail_comp = mag;
			ZONE_COLD: rail_comp = -mag;
			default:   rail_comp = '0;
		endcase
	endfunction

	cfg_t cfg;

	lmc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic [13:1] en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	logic [39:0] prod1_s1;
	logic        dual_s1, dual_s2, dual_s3, dual_s4, dual_s5, dual_s6, dual_s7;
	logic        dual_s8, dual_s9, dual_s10, dual_s11, dual_s12;
	logic [36:0] pa_ll_s2, pa_lh_s2;
	logic [37:0] pa_hl_s2, pa_hh_s2;
	logic signed [31:0] uv_s3;
	logic signed [47:0] p2_s4;
	logic [46:0] mag_s5;
	logic        neg_s5, neg_s6, neg_s7;
	logic [32:0] pb_ll_s6, pb_lh_s6;
	logic [33:0] pb_hl_s6, pb_hh_s6;
	logic        big_s6;
	logic [23:0] t2_s7;
	logic signed [20:0] mc_s8, mc_s9, mc_s10, mc_s11, mc_s12;
	logic [40:0] prod_s9;
	logic        mneg_s9;
	logic [1:0]  zone_s10, zone_s11, zone_s12;
	logic        sat_s10, sat_s11, sat_s12;
	logic [4:0]  a_s10;
	logic [12:0] ad0_s11, ad1_s11;
	logic [7:0]  d0_s11, d1_s11, d0_s12, d1_s12;
	logic [27:0] q0_s12, q1_s12;
	out_t        res_s13;

	logic [36:0] y2;
	logic [74:0] sum3;
	logic signed [31:0] uv3;
	logic signed [48:0] p4;
	logic        neg5;
	logic [46:0] mag5;
	logic [42:0] z6;
	logic [66:0] sum7;
	logic [22:0] toff100;
	logic signed [25:0] mcf8;
	logic signed [20:0] mc8;
	logic        mneg9;
	logic [19:0] mabs9;
	logic [9:0]  icm10;
	logic signed [10:0] ic10;
	logic signed [11:0] diff10, cneg10;
	logic [7:0]  p0h, p1h, p0l, p1l;
	logic        hot10, cold10;
	logic [1:0]  zone10;
	logic        sat10;
	logic [4:0]  a10;
	logic [7:0]  d0_11, d1_11;
	logic [14:0] recip12;
	logic [15:0] comp0_13, comp1_13;

	assign en[13] = !vld_s13 || !result_stall;
	assign en[12] = !vld_s12 || en[13];
	assign en[11] = !vld_s11 || en[12];
	assign en[10] = !vld_s10 || en[11];
	assign en[9]  = !vld_s9  || en[10];
	assign en[8]  = !vld_s8  || en[9];
	assign en[7]  = !vld_s7  || en[8];
	assign en[6]  = !vld_s6  || en[7];
	assign en[5]  = !vld_s5  || en[6];
	assign en[4]  = !vld_s4  || en[5];
	assign en[3]  = !vld_s3  || en[4];
	assign en[2]  = !vld_s2  || en[3];
	assign en[1]  = !vld_s1  || en[2];

	assign sample_stall = !en[1];
	assign result_valid = vld_s13;
	assign result       = res_s13;

	assign p0h = cfg.etc_delta_word[7:0];
	assign p1h = cfg.etc_delta_word[15:8];
	assign p0l = cfg.etc_delta_word[23:16];
	assign p1l = cfg.etc_delta_word[31:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			if (en[1])  vld_s1  <= sample_valid;
			if (en[2])  vld_s2  <= vld_s1;
			if (en[3])  vld_s3  <= vld_s2;
			if (en[4])  vld_s4  <= vld_s3;
			if (en[5])  vld_s5  <= vld_s4;
			if (en[6])  vld_s6  <= vld_s5;
			if (en[7])  vld_s7  <= vld_s6;
			if (en[8])  vld_s8  <= vld_s7;
			if (en[9])  vld_s9  <= vld_s8;
			if (en[10]) vld_s10 <= vld_s9;
			if (en[11]) vld_s11 <= vld_s10;
			if (en[12]) vld_s12 <= vld_s11;
			if (en[13]) vld_s13 <= vld_s12;
		end
	end

	always_comb begin
		y2   = prod1_s1[39:3];
		sum3 = 75'(pa_ll_s2) + (75'(pa_lh_s2) << 19) + (75'(pa_hl_s2) << 18)
			+ (75'(pa_hh_s2) << 37);
		uv3  = $signed({1'b0, sum3[74:44]})
			+ $signed({{9{cfg.adc_offset_microvolt[22]}}, cfg.adc_offset_microvolt});
		p4   = $signed({1'b0, cfg.temp_slope_tenths}) * uv_s3;
		neg5 = p2_s4[47];
		mag5 = neg5 ? 47'(-p2_s4) : 47'(p2_s4);
		z6   = mag_s5[46:4];
		sum7 = 67'(pb_ll_s6) + (67'(pb_lh_s6) << 17) + (67'(pb_hl_s6) << 16)
			+ (67'(pb_hh_s6) << 33);
	end

	always_comb begin
		toff100 = 23'(cfg.temp_offset_tenths) * 23'(TOFF_SCALE);
		if (neg_s7) begin
			mcf8 = $signed({3'b0, toff100}) + $signed({2'b0, t2_s7});
		end else begin
			mcf8 = $signed({3'b0, toff100}) - $signed({2'b0, t2_s7});
		end
		if (mcf8 > MC_HI) begin
			mc8 = RES_HI;
		end else if (mcf8 < -MC_HI) begin
			mc8 = -RES_HI;
		end else begin
			mc8 = mcf8[20:0];
		end
		mneg9 = mc_s8[20];
		mabs9 = mneg9 ? 20'(-mc_s8) : 20'(mc_s8);
	end

	always_comb begin
		icm10  = prod_s9[39:30];
		ic10   = mneg_s9 ? -$signed({1'b0, icm10}) : $signed({1'b0, icm10});
		diff10 = $signed({ic10[10], ic10}) - $signed({4'b0, cfg.norm_temp_deg});
		cneg10 = -(diff10 + COLD_GAP);
		hot10  = (diff10 > 12'sd0) && ((|p0h) || (|p1h));
		cold10 = (diff10 < -COLD_GAP) && ((|p0l) || (|p1l));
		zone10 = ZONE_NONE;
		sat10  = 1'b0;
		a10    = '0;
		if (hot10) begin
			zone10 = ZONE_HOT;
			sat10  = diff10 > HOT_SPAN;
			a10    = sat10 ? 5'd0 : diff10[4:0];
		end else if (cold10) begin
			zone10 = ZONE_COLD;
			sat10  = diff10 < -COLD_SPAN;
			a10    = sat10 ? 5'd0 : cneg10[4:0];
		end
		d0_11    = (zone_s10 == ZONE_HOT) ? p0h : p0l;
		d1_11    = (zone_s10 == ZONE_HOT) ? p1h : p1l;
		recip12  = (zone_s11 == ZONE_HOT) ? RECIP_25 : RECIP_10;
		comp0_13 = rail_comp(zone_s12, sat_s12, d0_s12, q0_s12[27:18]);
		comp1_13 = rail_comp(zone_s12, sat_s12, d1_s12, q1_s12[27:18]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			prod1_s1 <= 40'(cfg.adc_slope_nanovolt) * 40'(sample.temp_code);
			dual_s1  <= sample.mode == MODE_DUAL_CLOSED;
		end
		if (en[2]) begin
			pa_ll_s2 <= 37'(y2[17:0]) * 37'(RECIP_125[18:0]);
			pa_lh_s2 <= 37'(y2[17:0]) * 37'(RECIP_125[37:19]);
			pa_hl_s2 <= 38'(y2[36:18]) * 38'(RECIP_125[18:0]);
			pa_hh_s2 <= 38'(y2[36:18]) * 38'(RECIP_125[37:19]);
			dual_s2  <= dual_s1;
		end
		if (en[3]) begin
			uv_s3   <= uv3;
			dual_s3 <= dual_s2;
		end
		if (en[4]) begin
			p2_s4   <= $signed(p4[47:0]);
			dual_s4 <= dual_s3;
		end
		if (en[5]) begin
			mag_s5  <= mag5;
			neg_s5  <= neg5;
			dual_s5 <= dual_s4;
		end
		if (en[6]) begin
			pb_ll_s6 <= 33'(z6[15:0]) * 33'(RECIP_625[16:0]);
			pb_lh_s6 <= 33'(z6[15:0]) * 33'(RECIP_625[33:17]);
			pb_hl_s6 <= 34'(z6[32:16]) * 34'(RECIP_625[16:0]);
			pb_hh_s6 <= 34'(z6[32:16]) * 34'(RECIP_625[33:17]);
			big_s6   <= z6 >= 43'(FIT_BIG_Z);
			neg_s6   <= neg_s5;
			dual_s6  <= dual_s5;
		end
		if (en[7]) begin
			t2_s7   <= big_s6 ? FIT_CLAMP : sum7[66:43];
			neg_s7  <= neg_s6;
			dual_s7 <= dual_s6;
		end
		if (en[8]) begin
			mc_s8   <= mc8;
			dual_s8 <= dual_s7;
		end
		if (en[9]) begin
			prod_s9 <= 41'(mabs9) * 41'(RECIP_1000);
			mneg_s9 <= mneg9;
			mc_s9   <= mc_s8;
			dual_s9 <= dual_s8;
		end
		if (en[10]) begin
			zone_s10 <= zone10;
			sat_s10  <= sat10;
			a_s10    <= a10;
			mc_s10   <= mc_s9;
			dual_s10 <= dual_s9;
		end
		if (en[11]) begin
			ad0_s11  <= 13'(a_s10) * 13'(d0_11);
			ad1_s11  <= 13'(a_s10) * 13'(d1_11);
			d0_s11   <= d0_11;
			d1_s11   <= d1_11;
			zone_s11 <= zone_s10;
			sat_s11  <= sat_s10;
			mc_s11   <= mc_s10;
			dual_s11 <= dual_s10;
		end
		if (en[12]) begin
			q0_s12   <= 28'(ad0_s11) * 28'(recip12);
			q1_s12   <= 28'(ad1_s11) * 28'(recip12);
			d0_s12   <= d0_s11;
			d1_s12   <= d1_s11;
			zone_s12 <= zone_s11;
			sat_s12  <= sat_s11;
			mc_s12   <= mc_s11;
			dual_s12 <= dual_s11;
		end
		if (en[13]) begin
			res_s13.ic_temp_millideg <= mc_s12;
			res_s13.mpdl_target      <= dual_s12 ? {6'b0, cfg.p0_base_target} + comp0_13 : '0;
			res_s13.mpdh_target      <= dual_s12 ? {6'b0, cfg.p1_base_target} + comp1_13 : '0;
			res_s13.targets_written  <= dual_s12;
		end
	end

	`LMC_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, sample_valid && !sample_stall, vld_s1)
	`LMC_ASSERT_IMP(a_idle_out_no_stall, clk, arst_n, !result_valid, !sample_stall)
	`LMC_ASSERT_IMP(a_skip_zero_targets, clk, arst_n, result_valid && !result.targets_written,
		result.mpdl_target == 16'd0 && result.mpdh_target == 16'd0)
	`LMC_ASSERT_IMP(a_temp_in_range, clk, arst_n, result_valid,
		result.ic_temp_millideg <= RES_HI && result.ic_temp_millideg >= -RES_HI)

endmodule
